### src/hop_count_table_macros.svh
// Assertion macros for the hop count table.
// Included by the modules that check their own logic; depends on nothing.
`ifndef HOP_COUNT_TABLE_MACROS_SVH
`define HOP_COUNT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define HCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define HCT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define HCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define HCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define HCT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/hct_pkg.sv
// Package of the hop count table: request, result and entry types, codes
// and the hop count inference function. Depends on nothing.
package hct_pkg;

  localparam logic FUNC_LEARN   = 1'b0;
  localparam logic FUNC_REFRESH = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_SKIPPED  = 3'd4
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_SEARCH
  } ctrl_state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] src_addr;
    logic [7:0]  ttl;
    logic        established;
  } hct_req_t;

  typedef struct packed {
    logic [6:0] hop_count;
    status_e    status;
    logic [3:0] slot;
  } hct_res_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [6:0]  hops;
  } hct_entry_t;

  function automatic logic [6:0] hct_infer_hops(input logic [7:0] ttl);
    logic [7:0] init;
    logic [7:0] diff;
    if (ttl <= 8'd30) begin
      init = 8'd30;
    end else if (ttl <= 8'd32) begin
      init = 8'd32;
    end else if (ttl <= 8'd60) begin
      init = 8'd60;
    end else if (ttl <= 8'd64) begin
      init = 8'd64;
    end else if (ttl <= 8'd128) begin
      init = 8'd128;
    end else begin
      init = 8'd255;
    end
    diff = init - ttl;
    return diff[6:0];
  endfunction

endpackage

### src/hct_mem.sv
// Entry memory of the hop count table: one write port and one registered read port.
// Depends on hct_pkg for the entry type.
module hct_mem
  import hct_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hct_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output hct_entry_t    rdata_o
);

  hct_entry_t mem_q [DEPTH];
  hct_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/hct_ctrl.sv
// Controller of the hop count table: request handling, fill count, entry search
// and result register. Depends on hct_pkg and hop_count_table_macros.svh.
`include "hop_count_table_macros.svh"
module hct_ctrl
  import hct_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  hct_req_t         req_i,
  output logic             result_valid_o,
  output hct_res_t         res_o,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output hct_entry_t       mem_wdata_o,
  output logic             mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  hct_entry_t       mem_rdata_i
);

  ctrl_state_e      state_q, state_d;
  hct_req_t         req_q, req_d;
  logic [6:0]       hops_q, hops_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             res_valid_q, res_valid_d;
  hct_res_t         res_q, res_d;
  logic [6:0]       hops_now;

  function automatic logic [3:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  assign hops_now = hct_infer_hops(req_i.ttl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    hops_q <= hops_d;
    ridx_q <= ridx_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    hops_d      = hops_q;
    fill_d      = fill_q;
    ridx_d      = ridx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          req_d           = req_i;
          hops_d          = hops_now;
          res_d.hop_count = hops_now;
          res_d.slot      = '0;
          if (req_i.func == FUNC_LEARN) begin
            res_valid_d = 1'b1;
            if (fill_q < CNT_W'(ENTRIES)) begin
              mem_we_o         = 1'b1;
              mem_waddr_o      = fill_q[IDX_W-1:0];
              mem_wdata_o.addr = req_i.src_addr;
              mem_wdata_o.hops = hops_now;
              res_d.status     = ST_STORED;
              res_d.slot       = slot_of(fill_q[IDX_W-1:0]);
              fill_d           = fill_q + CNT_W'(1);
            end else begin
              res_d.status = ST_FULL;
            end
          end else if (!req_i.established) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_SKIPPED;
          end else if (fill_q == '0) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_NO_MATCH;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            ridx_d      = '0;
            state_d     = CS_SEARCH;
          end
        end
      end
      CS_SEARCH: begin
        if (mem_rdata_i.addr == req_q.src_addr) begin
          mem_we_o         = 1'b1;
          mem_waddr_o      = ridx_q;
          mem_wdata_o.addr = mem_rdata_i.addr;
          mem_wdata_o.hops = hops_q;
          res_valid_d      = 1'b1;
          res_d.status     = ST_UPDATED;
          res_d.slot       = slot_of(ridx_q);
          state_d          = CS_IDLE;
        end else if ((CNT_W'(ridx_q) + CNT_W'(1)) == fill_q) begin
          res_valid_d  = 1'b1;
          res_d.status = ST_NO_MATCH;
          state_d      = CS_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ridx_q + IDX_W'(1);
          ridx_d      = ridx_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != CS_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  `HCT_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > CNT_W'(ENTRIES), "fill count beyond table size")
  `HCT_ASSERT_NEVER(a_no_rw_clash, clk_i, rst_ni, mem_we_o && mem_re_o, "memory read and write in one cycle")
  `HCT_ASSERT_IMPLY(a_search_written, clk_i, rst_ni, state_q == CS_SEARCH, CNT_W'(ridx_q) < fill_q, "search beyond written entries")
  `HCT_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o, busy_o || result_valid_o, "accepted request neither searched nor answered")

endmodule

### src/hop_count_table.sv
// Top level of the hop count table: source address to inferred hop count.
// Depends on hct_pkg, hct_mem and hct_ctrl.
//
// A request on req_i is taken at a rising edge where start is high and busy is
// low. Every request yields exactly one result on res_o, shown for one cycle
// with result_valid_o high; the receiver cannot hold it off.
// Learn requests, refresh requests that are not established and refresh
// requests on an empty table answer one cycle after acceptance and leave busy
// low, so one request may be taken every cycle.
// A refresh request on an established connection reads the written entries
// from index 0 upward through the single read port of the entry memory, one
// entry per cycle. It answers once the search hits or has passed every written
// entry; busy stays high while the search runs.
// A new request may be taken in the cycle in which the previous result is
// shown; the result register holds it independently.
// Reset clears the fill count and the controller; entry contents are left as
// they are and only written entries are ever searched.
module hop_count_table
  import hct_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  hct_req_t req_i,
  output logic     result_valid_o,
  output hct_res_t res_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  hct_entry_t       mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  hct_entry_t       mem_rdata;

  hct_ctrl #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  hct_mem #(
    .DEPTH(ENTRIES),
    .AW   (IDX_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
